FILE: hdl/pshp_pkg.sv
// Package for the program stream system header parser: types and constants.
`default_nettype none

package pshp_pkg;

  localparam int MAX_STREAMS = 32;
  localparam int ENTRY_CNT_W = 9;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);

  localparam logic [7:0]  EXT_STREAM_ID = 8'hB7;
  localparam logic [15:0] MIN_LENGTH    = 16'd6;

  typedef enum logic [1:0] {
    KIND_FIXED = 2'd0,
    KIND_ENTRY = 2'd1,
    KIND_DONE  = 2'd2,
    KIND_ERROR = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    PH_ENTRY_ID = 3'd0,
    PH_EXT_C0   = 3'd1,
    PH_EXT_ID   = 3'd2,
    PH_EXT_B6   = 3'd3,
    PH_SIZE_HI  = 3'd4,
    PH_SIZE_LO  = 3'd5,
    PH_LEN_LO   = 3'd6,
    PH_FIXED    = 3'd7
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       header_start;
    logic       end_of_data;
  } in_t;

  typedef struct packed {
    kind_t       kind;
    logic [21:0] peak_rate;
    logic [5:0]  audio_max;
    logic [4:0]  video_max;
    logic [4:0]  flag_bits;
    logic [7:0]  stream_ident;
    logic        extended;
    logic        bound_scale;
    logic [12:0] size_bound;
    logic        last;
  } out_t;

endpackage

`default_nettype wire

FILE: hdl/ps_system_header_parser_core.sv
// Program stream system header parser: byte-wide parse logic and result queue.
// Latency: a result is written to the output queue at the edge that accepts its byte
//   and is presented on out_valid from the next cycle.
// Throughput: one byte per cycle; a byte may cause up to two results in a four-entry queue,
//   drained one per cycle while out_ready is set; in_ready drops with under two slots free.
// Reset: synchronous, active low; clears the parse state and empties the queue.
`default_nettype none

module ps_system_header_parser_core (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire pshp_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output pshp_pkg::out_t      out_data
);

  localparam int QCW = pshp_pkg::QUEUE_CNT_W;
  localparam int QIW = pshp_pkg::QUEUE_IDX_W;

  // Parse state.
  logic [15:0]                        byte_pos_r, byte_pos_nxt;
  logic [15:0]                        hdr_len_r, hdr_len_nxt;
  logic [21:0]                        rate_r, rate_nxt;
  logic [15:0]                        fixed_r, fixed_nxt;
  logic [pshp_pkg::ENTRY_CNT_W-1:0]   entry_cnt_r, entry_cnt_nxt;
  pshp_pkg::phase_t                   phase_r, phase_nxt;
  logic [7:0]                         ident_r, ident_nxt;
  logic [7:0]                         size_hi_r, size_hi_nxt;
  logic                               skip_r, skip_nxt;
  logic                               active_r, active_nxt;

  // Result queue; the head is always slot zero.
  pshp_pkg::out_t                     q_r [pshp_pkg::QUEUE_DEPTH];
  pshp_pkg::out_t                     q_nxt [pshp_pkg::QUEUE_DEPTH];
  logic [QCW-1:0]                     q_count_r, q_count_nxt;

  logic                               in_acc;
  logic                               out_acc;
  logic [1:0]                         res_n;
  pshp_pkg::out_t                     res0, res1;

  assign in_ready  = (q_count_r <= QCW'(2));
  assign in_acc    = in_valid && in_ready;
  assign out_valid = (q_count_r != '0);
  assign out_acc   = out_valid && out_ready;
  assign out_data  = q_r[0];

  // Parse one byte and produce up to two results.
  always_comb begin
    logic [7:0]  b;
    logic [15:0] len_full;
    logic [16:0] pos_inc;
    logic        last_byte;
    logic [15:0] remain;
    logic [7:0]  hi;
    logic [7:0]  lo;
    pshp_pkg::out_t r;
    pshp_pkg::out_t tail;

    b         = in_data.data_byte;
    len_full  = {hdr_len_r[15:8], b};
    pos_inc   = {1'b0, byte_pos_r} + 17'd1;
    last_byte = (pos_inc == {1'b0, hdr_len_r});
    remain    = hdr_len_r - byte_pos_r;
    hi        = fixed_r[15:8];
    lo        = fixed_r[7:0];
    r         = '0;
    tail      = '0;

    byte_pos_nxt  = byte_pos_r;
    hdr_len_nxt   = hdr_len_r;
    rate_nxt      = rate_r;
    fixed_nxt     = fixed_r;
    entry_cnt_nxt = entry_cnt_r;
    phase_nxt     = phase_r;
    ident_nxt     = ident_r;
    size_hi_nxt   = size_hi_r;
    skip_nxt      = skip_r;
    active_nxt    = active_r;
    res_n         = 2'd0;
    res0          = '0;
    res1          = '0;

    if (in_acc) begin
      if (in_data.header_start) begin
        hdr_len_nxt   = {b, 8'h00};
        byte_pos_nxt  = '0;
        rate_nxt      = '0;
        fixed_nxt     = '0;
        entry_cnt_nxt = '0;
        phase_nxt     = pshp_pkg::PH_LEN_LO;
        ident_nxt     = '0;
        size_hi_nxt   = '0;
        skip_nxt      = 1'b0;
        active_nxt    = 1'b1;
        if (in_data.end_of_data) begin
          res0       = '0;
          res0.kind  = pshp_pkg::KIND_ERROR;
          res0.last  = 1'b1;
          res_n      = 2'd1;
          active_nxt = 1'b0;
        end
      end else if (active_r) begin
        if (phase_r == pshp_pkg::PH_LEN_LO) begin
          hdr_len_nxt  = len_full;
          byte_pos_nxt = '0;
          if (len_full < pshp_pkg::MIN_LENGTH || in_data.end_of_data) begin
            res0.kind  = pshp_pkg::KIND_ERROR;
            res0.last  = 1'b1;
            res_n      = 2'd1;
            active_nxt = 1'b0;
          end else begin
            phase_nxt = pshp_pkg::PH_FIXED;
          end
        end else begin
          if (phase_r == pshp_pkg::PH_FIXED) begin
            case (byte_pos_r)
              16'd0: rate_nxt = {b[6:0], 15'd0};
              16'd1: rate_nxt = rate_r | {7'd0, b, 7'd0};
              16'd2: rate_nxt = rate_r | {15'd0, b[7:1]};
              16'd3: fixed_nxt = {b, fixed_r[7:0]};
              16'd4: fixed_nxt = {fixed_r[15:8], b};
              default: begin
                r.kind        = pshp_pkg::KIND_FIXED;
                r.peak_rate   = rate_r;
                r.audio_max   = hi[7:2];
                r.video_max   = lo[4:0];
                r.flag_bits   = {hi[1], hi[0], lo[7], lo[6], b[7]};
                res0          = r;
                res_n         = 2'd1;
                phase_nxt     = pshp_pkg::PH_ENTRY_ID;
              end
            endcase
          end else begin
            unique case (phase_r)
              pshp_pkg::PH_ENTRY_ID: begin
                if (skip_r ||
                    entry_cnt_r >= pshp_pkg::ENTRY_CNT_W'(pshp_pkg::MAX_STREAMS) ||
                    remain < 16'd2 || !b[7]) begin
                  skip_nxt = 1'b1;
                end else begin
                  ident_nxt = b;
                  phase_nxt = (b == pshp_pkg::EXT_STREAM_ID) ? pshp_pkg::PH_EXT_C0
                                                             : pshp_pkg::PH_SIZE_HI;
                end
              end
              pshp_pkg::PH_EXT_C0: phase_nxt = pshp_pkg::PH_EXT_ID;
              pshp_pkg::PH_EXT_ID: begin
                ident_nxt = {1'b0, b[6:0]};
                phase_nxt = pshp_pkg::PH_EXT_B6;
              end
              pshp_pkg::PH_EXT_B6: phase_nxt = pshp_pkg::PH_SIZE_HI;
              pshp_pkg::PH_SIZE_HI: begin
                size_hi_nxt = b;
                phase_nxt   = pshp_pkg::PH_SIZE_LO;
              end
              default: begin
                r.kind         = pshp_pkg::KIND_ENTRY;
                r.stream_ident = ident_r;
                r.extended     = !ident_r[7];
                r.bound_scale  = size_hi_r[5];
                r.size_bound   = {size_hi_r[4:0], b};
                res0           = r;
                res_n          = 2'd1;
                entry_cnt_nxt  = entry_cnt_r + pshp_pkg::ENTRY_CNT_W'(1);
                phase_nxt      = pshp_pkg::PH_ENTRY_ID;
              end
            endcase
          end

          byte_pos_nxt = pos_inc[15:0];

          // The header closes on its last body byte or when the data runs out.
          if (last_byte || in_data.end_of_data) begin
            tail.kind = (last_byte && phase_nxt == pshp_pkg::PH_ENTRY_ID)
                        ? pshp_pkg::KIND_DONE : pshp_pkg::KIND_ERROR;
            tail.last  = 1'b1;
            active_nxt = 1'b0;
            if (res_n == 2'd0) begin
              res0  = tail;
              res_n = 2'd1;
            end else begin
              res1  = tail;
              res_n = 2'd2;
            end
          end
        end
      end
    end
  end

  // Queue update: shift on a pop, then append the new results behind the survivors.
  always_comb begin
    logic [QCW-1:0] base;
    base = out_acc ? (q_count_r - QCW'(1)) : q_count_r;
    for (int i = 0; i < pshp_pkg::QUEUE_DEPTH; i++) begin
      if (out_acc && i < pshp_pkg::QUEUE_DEPTH - 1) begin
        q_nxt[i] = q_r[QIW'(i + 1)];
      end else begin
        q_nxt[i] = q_r[i];
      end
      if (res_n != 2'd0 && base == QCW'(i)) begin
        q_nxt[i] = res0;
      end
      if (res_n == 2'd2 && base + QCW'(1) == QCW'(i)) begin
        q_nxt[i] = res1;
      end
    end
    q_count_nxt = base + QCW'(res_n);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r  <= '0;
      hdr_len_r   <= '0;
      rate_r      <= '0;
      fixed_r     <= '0;
      entry_cnt_r <= '0;
      phase_r     <= pshp_pkg::PH_ENTRY_ID;
      ident_r     <= '0;
      size_hi_r   <= '0;
      skip_r      <= 1'b0;
      active_r    <= 1'b0;
      q_count_r   <= '0;
    end else begin
      byte_pos_r  <= byte_pos_nxt;
      hdr_len_r   <= hdr_len_nxt;
      rate_r      <= rate_nxt;
      fixed_r     <= fixed_nxt;
      entry_cnt_r <= entry_cnt_nxt;
      phase_r     <= phase_nxt;
      ident_r     <= ident_nxt;
      size_hi_r   <= size_hi_nxt;
      skip_r      <= skip_nxt;
      active_r    <= active_nxt;
      q_count_r   <= q_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < pshp_pkg::QUEUE_DEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  // The queue never holds more results than it has slots.
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count_r <= QCW'(pshp_pkg::QUEUE_DEPTH))
    else $error("result queue overfilled");

  // A pop with no new request shrinks the queue by exactly one.
  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && !in_acc) |=> (q_count_r == $past(q_count_r) - QCW'(1)))
    else $error("result queue count slipped on a pop");

  // While the body is being parsed the position stays inside the header.
  a_pos_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r && phase_r != pshp_pkg::PH_LEN_LO) |-> (byte_pos_r < hdr_len_r))
    else $error("byte position ran past the header length");

  // The entry count never passes the stream limit.
  a_entry_limit: assert property (@(posedge clk) disable iff (!rst_n)
    entry_cnt_r <= pshp_pkg::ENTRY_CNT_W'(pshp_pkg::MAX_STREAMS))
    else $error("entry count above the stream limit");

endmodule

`default_nettype wire
